// File: hdl/tsoc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tsoc_pkg;

    localparam logic [29:0] NS_PER_S = 30'd1_000_000_000;
    localparam logic signed [38:0] NS_PER_MIN = 39'sd60_000_000_000;
    localparam logic signed [37:0] SHIFT_LOW = -38'sd60_000_000_000;
    localparam logic signed [37:0] SHIFT_HIGH = 38'sd120_000_000_000;

    // Quotient estimate: floor(x / 1e9) ~= ((x >> 24) * floor(2^44 / 1e9)) >> 20.
    // The estimate is low by at most one.
    localparam logic [14:0] RECIP_NS_PER_S = 15'((64'd1 << 44) / 64'd1_000_000_000);

    // floor(year / 100) == (year * 5243) >> 19 for every 12-bit year.
    localparam logic [12:0] YEAR_DIV100_MUL = 13'd5243;
    localparam logic [12:0] YEARS_PER_CENTURY = 13'd100;

    localparam logic [7:0] SEC_PER_MIN = 8'd60;
    localparam logic [6:0] MIN_PER_HOUR = 7'd60;
    localparam logic [5:0] HOUR_PER_DAY = 6'd24;
    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;
    localparam logic [4:0] DAY_FIRST = 5'd1;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
    } cal_t;

    typedef struct packed {
        cal_t               cal;
        logic [35:0]        secns;
        logic signed [36:0] trig;
    } in_item_t;

    typedef struct packed {
        cal_t cal;
        logic err;
        logic leap;
    } side_t;

    typedef struct packed {
        side_t       side;
        logic [37:0] dividend;
    } div_in_t;

    typedef struct packed {
        side_t       side;
        logic [7:0]  sec;
        logic [29:0] frac;
    } div_out_t;

    typedef struct packed {
        cal_t        cal;
        logic [5:0]  second;
        logic [29:0] frac;
        logic        status;
    } out_item_t;

    function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        len = 5'd31;
        if (month == MONTH_FEB) begin
            len = leap ? 5'd29 : 5'd28;
        end else if (month inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
            len = 5'd30;
        end
        return len;
    endfunction

endpackage

`default_nettype wire

// File: hdl/tsoc_shift.sv
`timescale 1ns / 1ps
`default_nettype none

module tsoc_shift import tsoc_pkg::*; (
    input  wire logic        aclk,
    input  wire logic [1:0]  en,
    input  wire in_item_t    item,
    input  wire logic [36:0] offset,
    output div_in_t          div_in
);

    cal_t               cal_reg;
    logic [35:0]        secns_reg;
    logic signed [37:0] shift_reg;
    logic [5:0]         cent_reg;
    logic signed [37:0] shift_next;
    logic [24:0]        year_prod;
    div_in_t            div_in_reg;
    div_in_t            div_in_next;
    logic signed [38:0] total;
    logic signed [38:0] total_up;
    logic signed [38:0] secns_ext;
    logic signed [38:0] shift_ext;
    logic               range_err;
    logic               neg;
    logic               err;
    logic [12:0]        cent_years;
    logic               div100;

    always_comb begin
        shift_next = $signed({item.trig[36], item.trig}) - $signed({offset[36], offset});
        year_prod = 25'(item.cal.year) * 25'(YEAR_DIV100_MUL);
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            cal_reg   <= item.cal;
            secns_reg <= item.secns;
            shift_reg <= shift_next;
            cent_reg  <= year_prod[24:19];
        end
    end

    always_comb begin
        secns_ext = $signed({3'b000, secns_reg});
        shift_ext = $signed({shift_reg[37], shift_reg});
        total     = secns_ext + shift_ext;
        total_up  = secns_ext + shift_ext + NS_PER_MIN;
        range_err = (shift_reg < SHIFT_LOW) || (shift_reg >= SHIFT_HIGH);
        neg       = total[38];
        err       = range_err || (neg && (cal_reg.minute == 6'd0));

        // A year divisible by 400 is one divisible by 100 whose century count is a multiple of 4.
        cent_years = 13'(cent_reg) * YEARS_PER_CENTURY;
        div100     = (cent_years == {1'b0, cal_reg.year});

        div_in_next           = '0;
        div_in_next.side.cal  = cal_reg;
        div_in_next.side.err  = err;
        div_in_next.side.leap = (cal_reg.year[1:0] == 2'd0) &&
                                (!div100 || (cent_reg[1:0] == 2'd0));
        if (err) begin
            div_in_next.dividend = {2'b00, secns_reg};
        end else if (neg) begin
            div_in_next.dividend       = total_up[37:0];
            div_in_next.side.cal.minute = cal_reg.minute - 6'd1;
        end else begin
            div_in_next.dividend = total[37:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            div_in_reg <= div_in_next;
        end
    end

    assign div_in = div_in_reg;

endmodule

`default_nettype wire

// File: hdl/tsoc_div.sv
`timescale 1ns / 1ps
`default_nettype none

module tsoc_div import tsoc_pkg::*; (
    input  wire logic [2:0] en,
    input  wire logic       aclk,
    input  wire div_in_t    div_in,
    output div_out_t        div_out
);

    div_in_t      est_in_reg;
    logic [7:0]   est_reg;
    logic [28:0]  est_prod;
    div_in_t      mul_in_reg;
    logic [7:0]   mul_est_reg;
    logic [37:0]  prod_reg;
    logic [37:0]  prod_next;
    logic [38:0]  rem0;
    logic [38:0]  rem1;
    div_out_t     div_out_reg;
    div_out_t     div_out_next;

    assign est_prod = 29'(div_in.dividend[37:24]) * 29'(RECIP_NS_PER_S);

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            est_in_reg <= div_in;
            est_reg    <= est_prod[27:20];
        end
    end

    assign prod_next = 38'(est_reg) * 38'(NS_PER_S);

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            mul_in_reg  <= est_in_reg;
            mul_est_reg <= est_reg;
            prod_reg    <= prod_next;
        end
    end

    // The estimate is exact or one short; the second difference decides which.
    always_comb begin
        rem0 = {1'b0, mul_in_reg.dividend} - {1'b0, prod_reg};
        rem1 = {1'b0, mul_in_reg.dividend} - {1'b0, prod_reg} - 39'(NS_PER_S);
        div_out_next.side = mul_in_reg.side;
        if (!rem1[38]) begin
            div_out_next.sec  = mul_est_reg + 8'd1;
            div_out_next.frac = rem1[29:0];
        end else begin
            div_out_next.sec  = mul_est_reg;
            div_out_next.frac = rem0[29:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            div_out_reg <= div_out_next;
        end
    end

    assign div_out = div_out_reg;

endmodule

`default_nettype wire

// File: hdl/tsoc_carry.sv
`timescale 1ns / 1ps
`default_nettype none

module tsoc_carry import tsoc_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     en,
    input  wire div_out_t div_out,
    output out_item_t     result
);

    out_item_t  result_reg;
    out_item_t  result_next;
    logic [1:0] min_carry;
    logic [7:0] sec_left;
    logic [6:0] min_sum;
    logic       hour_carry;
    logic [5:0] hour_sum;
    logic       day_carry;
    logic [4:0] month_days;
    cal_t       cal;

    always_comb begin
        cal = div_out.side.cal;

        if (div_out.sec >= 8'(3 * SEC_PER_MIN)) begin
            min_carry = 2'd3;
            sec_left  = div_out.sec - 8'(3 * SEC_PER_MIN);
        end else if (div_out.sec >= 8'(2 * SEC_PER_MIN)) begin
            min_carry = 2'd2;
            sec_left  = div_out.sec - 8'(2 * SEC_PER_MIN);
        end else if (div_out.sec >= SEC_PER_MIN) begin
            min_carry = 2'd1;
            sec_left  = div_out.sec - SEC_PER_MIN;
        end else begin
            min_carry = 2'd0;
            sec_left  = div_out.sec;
        end

        min_sum    = {1'b0, cal.minute} + 7'(min_carry);
        hour_carry = (min_sum >= MIN_PER_HOUR);
        hour_sum   = {1'b0, cal.hour} + 6'(hour_carry);
        day_carry  = (hour_sum >= HOUR_PER_DAY);
        month_days = days_in(cal.month, div_out.side.leap);

        result_next.frac   = div_out.frac;
        result_next.status = div_out.side.err;
        if (div_out.side.err) begin
            result_next.cal    = cal;
            result_next.second = div_out.sec[5:0];
        end else begin
            result_next.second     = sec_left[5:0];
            result_next.cal        = cal;
            result_next.cal.minute = hour_carry ? 6'(min_sum - MIN_PER_HOUR) : min_sum[5:0];
            result_next.cal.hour   = day_carry ? 5'(hour_sum - HOUR_PER_DAY) : hour_sum[4:0];
            if (day_carry) begin
                // A day at or past the month length counts as the last day of the month.
                if (cal.day >= month_days) begin
                    result_next.cal.day = DAY_FIRST;
                    if (cal.month >= MONTH_DEC) begin
                        result_next.cal.month = MONTH_JAN;
                        result_next.cal.year  = cal.year + 12'd1;
                    end else begin
                        result_next.cal.month = cal.month + 4'd1;
                    end
                end else begin
                    result_next.cal.day = cal.day + 5'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

// File: hdl/timestamp_offset_calendar_carry_unit.sv
// Shifts a calendar timestamp by a signed trigger time minus the configured offset and
// normalizes seconds, minutes, hours and the Gregorian date, leap years included. One
// transfer is taken per cycle, and each result passes through the divide-by-one-billion
// path (quotient estimate, back-multiply, correction) that splits the nanosecond total
// into seconds and fraction, ahead of the carry into minutes, hours and the date.
// Stalls on the result side are absorbed by empty pipeline stages before the input
// stops. A net shift outside [-60 s, 120 s), or a negative total at minute zero, sets
// m_tuser and returns the input date and time unchanged. Write cfg_wr_data only while
// the pipeline is empty.
`timescale 1ns / 1ps
`default_nettype none

module timestamp_offset_calendar_carry_unit import tsoc_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_wr_en,
    input  wire logic [36:0]  cfg_wr_data,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // in_year, in_month, in_day, in_hour, in_minute, in_seconds_ns, trigger_time_ns
    input  wire logic [111:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // out_year, out_month, out_day, out_hour, out_minute, out_second, out_frac_ns
    output logic [71:0]       m_tdata,
    // status
    output logic              m_tuser
);

    localparam int STAGES = 7;

    logic [36:0]       offset_reg;
    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] adv;
    in_item_t          item_reg;
    in_item_t          item_next;
    div_in_t           div_in;
    div_out_t          div_out;
    out_item_t         result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= '0;
        end else if (cfg_wr_en) begin
            offset_reg <= cfg_wr_data;
        end
    end

    // A stage loads when it is empty or its contents move on in the same cycle.
    always_comb begin
        adv[STAGES-1] = !valid_reg[STAGES-1] || m_tready;
        for (int i = STAGES - 2; i >= 0; i--) begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
        valid_next = valid_reg;
        if (adv[0]) begin
            valid_next[0] = s_tvalid;
        end
        for (int i = 1; i < STAGES; i++) begin
            if (adv[i]) begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_comb begin
        item_next.cal.year   = s_tdata[11:0];
        item_next.cal.month  = s_tdata[15:12];
        item_next.cal.day    = s_tdata[20:16];
        item_next.cal.hour   = s_tdata[25:21];
        item_next.cal.minute = s_tdata[31:26];
        item_next.secns      = s_tdata[67:32];
        item_next.trig       = $signed(s_tdata[104:68]);
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            item_reg <= item_next;
        end
    end

    tsoc_shift u_shift (
        .aclk   (aclk),
        .en     (adv[2:1]),
        .item   (item_reg),
        .offset (offset_reg),
        .div_in (div_in)
    );

    tsoc_div u_div (
        .en      (adv[5:3]),
        .aclk    (aclk),
        .div_in  (div_in),
        .div_out (div_out)
    );

    tsoc_carry u_carry (
        .aclk    (aclk),
        .en      (adv[6]),
        .div_out (div_out),
        .result  (result)
    );

    assign s_tready = adv[0];
    assign m_tvalid = valid_reg[STAGES-1];
    assign m_tuser  = result.status;
    assign m_tdata  = {4'b0000, result.frac, result.second, result.cal.minute,
                       result.cal.hour, result.cal.day, result.cal.month, result.cal.year};

endmodule

`default_nettype wire
